// File: rtl/core/tfj_pkg.sv
// tfj_pkg: shared constants for the text full justifier
// character, configuration register and APB decode definitions
// no dependencies
`timescale 1ns / 1ps

package tfj_pkg;

    localparam int CHAR_W = 8;
    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

    localparam int CFG_W = 6;
    localparam logic [CFG_W-1:0] LINE_WIDTH_RST = 6'd16;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-3:0] REG_LINE_WIDTH = '0;

endpackage

// File: rtl/core/tfj_if.sv
// tfj_if: request channels of the text full justifier
// character input channel and justified character output channel
// depends on tfj_pkg
`timescale 1ns / 1ps

interface tfj_in_if;
    import tfj_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] in_char;
    logic              word_end;
    logic              text_end;

    modport source(output valid, output in_char, output word_end, output text_end,
                   input ready);
    modport sink(input valid, input in_char, input word_end, input text_end,
                 output ready);
endinterface

interface tfj_out_if;
    import tfj_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              line_end;
    logic              run_last;

    modport source(output valid, output out_char, output line_end, output run_last,
                   input ready);
    modport sink(input valid, input out_char, input line_end, input run_last,
                 output ready);
endinterface

// File: rtl/core/tfj_ram.sv
// tfj_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module tfj_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/tfj_apb.sv
// tfj_apb: apb configuration register holding the line width
// saturates the width to the supported range for the sequencer
// depends on tfj_pkg
`timescale 1ns / 1ps

module tfj_apb #(
    parameter int MAX_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tfj_pkg::APB_AW-1:0]         paddr,
    input  logic [tfj_pkg::APB_DW-1:0]         pwdata,
    output logic [tfj_pkg::APB_DW-1:0]         prdata,
    output logic                               pready,
    output logic [$clog2(MAX_WIDTH + 1)-1:0]   o_width
);
    import tfj_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam logic [CFG_W-1:0] MW = CFG_W'(MAX_WIDTH);

    logic [CFG_W-1:0] r_lw;
    logic             hit;

    assign hit    = (paddr[APB_AW-1:2] == REG_LINE_WIDTH);
    assign pready = 1'b1;
    assign prdata = hit ? APB_DW'(r_lw) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lw <= LINE_WIDTH_RST;
        end else if (psel && penable && pwrite && hit) begin
            r_lw <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        if (r_lw == '0) begin
            o_width = CW'(1);
        end else if (r_lw > MW) begin
            o_width = CW'(MAX_WIDTH);
        end else begin
            o_width = r_lw[CW-1:0];
        end
    end

endmodule

// File: rtl/core/tfj_div.sv
// tfj_div: restoring divider, one quotient bit per cycle
// splits the spare spaces of a line over its gaps
// no dependencies
`timescale 1ns / 1ps

module tfj_div #(
    parameter int DW = 6,
    parameter int VW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quo,
    output logic [VW-1:0] o_rem
);

    localparam int NW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [NW-1:0] r_n;
    logic [VW-1:0] r_acc;
    logic [DW-1:0] r_q;
    logic [VW-1:0] r_d;

    logic [VW:0]   sh;
    logic [VW:0]   diff;
    logic          ge;
    logic [VW-1:0] n_acc;

    always_comb begin
        sh    = {r_acc, r_q[DW-1]};
        diff  = sh - {1'b0, r_d};
        ge    = (sh >= {1'b0, r_d});
        n_acc = ge ? diff[VW-1:0] : sh[VW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_n    <= NW'(DW);
                r_acc  <= '0;
                r_q    <= i_dividend;
                r_d    <= i_divisor;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_q   <= {r_q[DW-2:0], ge};
                r_n   <= r_n - NW'(1);
                if (r_n == NW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = r_acc;

endmodule

// File: rtl/core/tfj_ctrl.sv
// tfj_ctrl: sequencer of the justifier, buffers words, packs lines, streams them out
// drives the word and line rams and the gap divider
// depends on tfj_pkg and tfj_if
`timescale 1ns / 1ps

module tfj_ctrl #(
    parameter int MAX_WIDTH = 32,
    parameter int MAX_WORDS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    tfj_in_if.sink                              i_in,
    tfj_out_if.source                           o_out,
    input  logic [$clog2(MAX_WIDTH + 1)-1:0]    i_width,
    output logic                                o_div_start,
    output logic [$clog2(MAX_WIDTH + 1)-1:0]    o_div_dividend,
    output logic [$clog2(MAX_WORDS + 1)-1:0]    o_div_divisor,
    input  logic                                i_div_done,
    input  logic [$clog2(MAX_WIDTH + 1)-1:0]    i_div_quo,
    input  logic [$clog2(MAX_WORDS + 1)-1:0]    i_div_rem,
    output logic                                o_wd_we,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_wd_waddr,
    output logic [tfj_pkg::CHAR_W-1:0]          o_wd_wdata,
    output logic                                o_wd_re,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_wd_raddr,
    input  logic [tfj_pkg::CHAR_W-1:0]          i_wd_rdata,
    output logic                                o_ln_we,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_ln_waddr,
    output logic [tfj_pkg::CHAR_W-1:0]          o_ln_wdata,
    output logic                                o_ln_re,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_ln_raddr,
    input  logic [tfj_pkg::CHAR_W-1:0]          i_ln_rdata
);
    import tfj_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int KW = $clog2(MAX_WORDS + 1);
    localparam int KI = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam logic [CW-1:0] MW = CW'(MAX_WIDTH);
    localparam logic [KW-1:0] MK = KW'(MAX_WORDS);

    typedef enum logic [2:0] {S_IDLE, S_COPY, S_DIV, S_DIVW, S_EA, S_EB} t_state;
    typedef enum logic [1:0] {PH_WORD, PH_GAP, PH_PAD} t_phase;

    t_state            r_state;
    t_phase            r_ph;
    logic [CW-1:0]     r_wlen;
    logic [CW-1:0]     r_len;
    logic              r_tend;
    logic              r_last;
    logic [KW-1:0]     r_cnt;
    logic [CW-1:0]     r_fill;
    logic [CW-1:0]     r_chars;
    logic [CW-1:0]     r_lens [MAX_WORDS];
    logic [CW-1:0]     r_ci;
    logic              r_cpend;
    logic [AW-1:0]     r_cwaddr;
    logic [CW-1:0]     r_pos;
    logic [KW-1:0]     r_k;
    logic [CW-1:0]     r_j;
    logic [CW-1:0]     r_src;
    logic [CW-1:0]     r_gap;
    logic [CW-1:0]     r_ave;
    logic [KW-1:0]     r_rem;
    logic              r_issp;
    logic              r_eend;
    logic              r_ov;
    logic [CHAR_W-1:0] r_och;
    logic              r_oend;
    logic              r_olast;

    logic              acc_in;
    logic              in_end;
    logic [CW-1:0]     n_wlen;
    logic [CW-1:0]     n_len;
    logic [CW+1:0]     fit_sum;
    logic              fits;
    logic [CW:0]       copy_sum;
    logic [CW+1:0]     fill_sum;
    logic [CW-1:0]     n_fill;
    logic [CW-1:0]     cur_len;
    logic              in_word;
    logic [CW-1:0]     gap_val;
    logic              emit_step;
    logic [CW-1:0]     n_pos;
    logic              out_free;

    assign i_in.ready = (r_state == S_IDLE);
    assign acc_in     = i_in.valid && (r_state == S_IDLE);
    assign in_end     = i_in.word_end || i_in.text_end;

    always_comb begin
        n_wlen   = (r_wlen < MW) ? r_wlen + CW'(1) : r_wlen;
        n_len    = (n_wlen < i_width) ? n_wlen : i_width;
        fit_sum  = (CW+2)'(r_fill) + (CW+2)'(n_len) + (CW+2)'(1);
        fits     = (r_cnt == '0) || ((r_cnt < MK) && (fit_sum <= (CW+2)'(i_width)));
        copy_sum = {1'b0, r_chars} + {1'b0, r_ci};
        fill_sum = (CW+2)'(r_fill) + (CW+2)'(r_len) + (CW+2)'(r_cnt != '0);
        n_fill   = (fill_sum > (CW+2)'(MW)) ? MW : fill_sum[CW-1:0];
        cur_len  = r_lens[r_k[KI-1:0]];
        in_word  = (r_j < cur_len);
        gap_val  = r_last ? CW'(1) : r_ave + CW'(r_k < r_rem);
        n_pos    = r_pos + CW'(1);
        out_free = !r_ov || o_out.ready;
        unique case (r_ph)
            PH_WORD: emit_step = in_word;
            PH_GAP:  emit_step = (r_gap != '0);
            PH_PAD:  emit_step = 1'b1;
            default: emit_step = 1'b1;
        endcase
    end

    // word buffer fill, copy into the line buffer and line buffer read for output
    assign o_wd_we    = acc_in && (r_wlen < MW);
    assign o_wd_waddr = r_wlen[AW-1:0];
    assign o_wd_wdata = i_in.in_char;
    assign o_wd_re    = (r_state == S_COPY) && (r_ci < r_len);
    assign o_wd_raddr = r_ci[AW-1:0];
    assign o_ln_we    = r_cpend;
    assign o_ln_waddr = r_cwaddr;
    assign o_ln_wdata = i_wd_rdata;
    assign o_ln_re    = (r_state == S_EA) && (r_ph == PH_WORD) && in_word;
    assign o_ln_raddr = r_src[AW-1:0];

    // spare spaces over gaps
    assign o_div_start    = (r_state == S_DIV) && !r_last && (r_cnt > KW'(1));
    assign o_div_dividend = (r_chars < i_width) ? i_width - r_chars : '0;
    assign o_div_divisor  = r_cnt - KW'(1);

    assign o_out.valid    = r_ov;
    assign o_out.out_char = r_och;
    assign o_out.line_end = r_oend;
    assign o_out.run_last = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wlen  <= '0;
            r_cnt   <= '0;
            r_fill  <= '0;
            r_chars <= '0;
            r_cpend <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_cpend <= (r_state == S_COPY) && (r_ci < r_len) && (copy_sum < {1'b0, MW});
            r_ov    <= ((r_state == S_EB) && out_free) || (r_ov && !o_out.ready);
            unique case (r_state)
                S_IDLE: begin
                    if (acc_in) begin
                        r_wlen <= n_wlen;
                        if (in_end) begin
                            r_len  <= n_len;
                            r_tend <= i_in.text_end;
                            r_ci   <= '0;
                            if (fits) begin
                                r_state <= S_COPY;
                            end else begin
                                r_last  <= 1'b0;
                                r_state <= S_DIV;
                            end
                        end
                    end
                end
                S_COPY: begin
                    if (r_ci < r_len) begin
                        r_ci     <= r_ci + CW'(1);
                        r_cwaddr <= copy_sum[AW-1:0];
                    end else begin
                        r_fill  <= n_fill;
                        r_chars <= r_chars + r_len;
                        r_cnt   <= r_cnt + KW'(1);
                        r_wlen  <= '0;
                        if (r_cnt < MK) begin
                            r_lens[r_cnt[KI-1:0]] <= r_len;
                        end
                        if (r_tend) begin
                            r_last  <= 1'b1;
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_DIV: begin
                    if (o_div_start) begin
                        r_state <= S_DIVW;
                    end else begin
                        r_ave   <= CW'(1);
                        r_rem   <= '0;
                        r_pos   <= '0;
                        r_k     <= '0;
                        r_j     <= '0;
                        r_src   <= '0;
                        r_ph    <= PH_WORD;
                        r_state <= S_EA;
                    end
                end
                S_DIVW: begin
                    if (i_div_done) begin
                        r_ave   <= i_div_quo;
                        r_rem   <= i_div_rem;
                        r_pos   <= '0;
                        r_k     <= '0;
                        r_j     <= '0;
                        r_src   <= '0;
                        r_ph    <= PH_WORD;
                        r_state <= S_EA;
                    end
                end
                S_EA: begin
                    unique case (r_ph)
                        PH_WORD: begin
                            if (in_word) begin
                                r_src  <= r_src + CW'(1);
                                r_j    <= r_j + CW'(1);
                                r_issp <= 1'b0;
                            end else if ((r_k + KW'(1)) < r_cnt) begin
                                r_gap <= gap_val;
                                r_k   <= r_k + KW'(1);
                                r_j   <= '0;
                                r_ph  <= PH_GAP;
                            end else begin
                                r_ph <= PH_PAD;
                            end
                        end
                        PH_GAP: begin
                            if (r_gap != '0) begin
                                r_gap  <= r_gap - CW'(1);
                                r_issp <= 1'b1;
                            end else begin
                                r_ph <= PH_WORD;
                            end
                        end
                        PH_PAD: begin
                            r_issp <= 1'b1;
                        end
                        default: begin
                            r_ph <= PH_PAD;
                        end
                    endcase
                    if (emit_step) begin
                        r_pos   <= n_pos;
                        r_eend  <= (n_pos == i_width);
                        r_state <= S_EB;
                    end
                end
                S_EB: begin
                    if (out_free) begin
                        r_och   <= r_issp ? SPACE_CHAR : i_ln_rdata;
                        r_oend  <= r_eend;
                        r_olast <= r_eend && (r_last || !r_tend);
                        if (r_eend) begin
                            r_cnt   <= '0;
                            r_fill  <= '0;
                            r_chars <= '0;
                            if (r_last) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_ci    <= '0;
                                r_state <= S_COPY;
                            end
                        end else begin
                            r_state <= S_EA;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/text_full_justifier.sv
// text_full_justifier: top level of the greedy full justification block
// depends on tfj_pkg, tfj_if, tfj_ram, tfj_apb, tfj_div and tfj_ctrl
//
// usage:
// characters arrive one request at a time on i_in, flagged with word_end and
// text_end; justified lines leave one character per request on o_out, each
// line exactly line_width characters, line_end on its last character and
// run_last on the last character caused by one input request.
// line_width is written over the apb port at address 0 while the block is idle.
// a character that does not end a word is written into the word ram and the block
// stays ready for the next one. a word end copies the word from the word ram into
// the line ram before the next input is taken. each output character is read from
// the line ram in S_EA and registered for output in S_EB; word and gap boundaries
// take extra S_EA steps. a justified line of two or more words first waits in
// S_DIVW for the serial gap divider, any other line goes from S_DIV to S_EA.
// reset clears the word and line state and sets line_width to 16; no ram
// clearing pass is needed.
// when the receiver stalls, the output register holds its character and the
// sequencer waits; no input is taken while a line is being emitted.
`timescale 1ns / 1ps

module text_full_justifier #(
    parameter int MAX_WIDTH = 32,
    parameter int MAX_WORDS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    tfj_in_if.sink                       i_in,
    tfj_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tfj_pkg::APB_AW-1:0]   paddr,
    input  logic [tfj_pkg::APB_DW-1:0]   pwdata,
    output logic [tfj_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import tfj_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int KW = $clog2(MAX_WORDS + 1);

    logic [CW-1:0]     width;
    logic              div_start;
    logic [CW-1:0]     div_dividend;
    logic [KW-1:0]     div_divisor;
    logic              div_done;
    logic [CW-1:0]     div_quo;
    logic [KW-1:0]     div_rem;
    logic              wd_we;
    logic [AW-1:0]     wd_waddr;
    logic [CHAR_W-1:0] wd_wdata;
    logic              wd_re;
    logic [AW-1:0]     wd_raddr;
    logic [CHAR_W-1:0] wd_rdata;
    logic              ln_we;
    logic [AW-1:0]     ln_waddr;
    logic [CHAR_W-1:0] ln_wdata;
    logic              ln_re;
    logic [AW-1:0]     ln_raddr;
    logic [CHAR_W-1:0] ln_rdata;

    tfj_apb #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_width (width)
    );

    tfj_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(MAX_WIDTH)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (wd_we),
        .i_waddr (wd_waddr),
        .i_wdata (wd_wdata),
        .i_re    (wd_re),
        .i_raddr (wd_raddr),
        .o_rdata (wd_rdata)
    );

    tfj_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ln_we),
        .i_waddr (ln_waddr),
        .i_wdata (ln_wdata),
        .i_re    (ln_re),
        .i_raddr (ln_raddr),
        .o_rdata (ln_rdata)
    );

    tfj_div #(
        .DW(CW),
        .VW(KW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    tfj_ctrl #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_WORDS(MAX_WORDS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (i_in),
        .o_out          (o_out),
        .i_width        (width),
        .o_div_start    (div_start),
        .o_div_dividend (div_dividend),
        .o_div_divisor  (div_divisor),
        .i_div_done     (div_done),
        .i_div_quo      (div_quo),
        .i_div_rem      (div_rem),
        .o_wd_we        (wd_we),
        .o_wd_waddr     (wd_waddr),
        .o_wd_wdata     (wd_wdata),
        .o_wd_re        (wd_re),
        .o_wd_raddr     (wd_raddr),
        .i_wd_rdata     (wd_rdata),
        .o_ln_we        (ln_we),
        .o_ln_waddr     (ln_waddr),
        .o_ln_wdata     (ln_wdata),
        .o_ln_re        (ln_re),
        .o_ln_raddr     (ln_raddr),
        .i_ln_rdata     (ln_rdata)
    );

endmodule
